@@ design/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, codes and constants of the tcp sender retransmit block.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_SEGS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_INITIAL_SEQUENCE = 2'd0;
    localparam logic [1:0] CFG_INITIAL_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD      = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [10:0] PAYLOAD_RESET = 11'd1000;

    // input operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic        ack_present;
        logic [31:0] ack_number;
        logic [15:0] window_advert;
        logic        peer_reset;
        logic [31:0] elapsed_ms;
        logic [15:0] stream_bytes;
        logic        stream_finished;
    } in_t;

    typedef struct packed {
        logic        seg_valid;
        logic [31:0] seg_seqno;
        logic        seg_syn;
        logic        seg_fin;
        logic        seg_rst;
        logic [10:0] payload_len;
        logic        is_retransmit;
        logic [16:0] in_flight;
        logic [7:0]  retrans_count;
        logic        last;
    } out_t;

    // commands from controller to datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_PUSH_INIT,
        CMD_PUSH_STEP,
        CMD_RECV,
        CMD_ACK_CHECK,
        CMD_RETIRE,
        CMD_TICK,
        CMD_RESEND,
        CMD_STATUS
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic push_more;
        logic ack_ok;
        logic retire_ok;
        logic expire;
    } stat_t;

endpackage

@@ design/tsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer that walks each input item through push, receive or tick steps.
// ----------------------------------------------------------------------------
module tsr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [1:0]     s_op,
    output logic           s_ready,
    input  tsr_pkg::stat_t stat,
    output tsr_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_INIT,
        S_PUSH_STEP,
        S_RECV,
        S_ACK_CHECK,
        S_ACK_WAIT,
        S_ACK_RETIRE,
        S_TICK,
        S_RESEND,
        S_STATUS
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd        = tsr_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd = tsr_pkg::CMD_CAPTURE;
                    case (s_op)
                        tsr_pkg::OP_PUSH: state_next = S_PUSH_INIT;
                        tsr_pkg::OP_RECV: state_next = S_RECV;
                        tsr_pkg::OP_TICK: state_next = S_TICK;
                        default:          state_next = S_STATUS;
                    endcase
                end
            end
            S_PUSH_INIT: begin
                cmd        = tsr_pkg::CMD_PUSH_INIT;
                state_next = S_PUSH_STEP;
            end
            S_PUSH_STEP: begin
                if (stat.out_free) begin
                    cmd = tsr_pkg::CMD_PUSH_STEP;
                    if (!stat.push_more) state_next = S_STATUS;
                end
            end
            S_RECV: begin
                cmd        = tsr_pkg::CMD_RECV;
                state_next = S_ACK_CHECK;
            end
            S_ACK_CHECK: begin
                cmd        = tsr_pkg::CMD_ACK_CHECK;
                state_next = stat.ack_ok ? S_ACK_WAIT : S_STATUS;
            end
            S_ACK_WAIT: begin
                state_next = S_ACK_RETIRE;
            end
            S_ACK_RETIRE: begin
                cmd        = tsr_pkg::CMD_RETIRE;
                state_next = stat.retire_ok ? S_ACK_WAIT : S_STATUS;
            end
            S_TICK: begin
                cmd        = tsr_pkg::CMD_TICK;
                state_next = stat.expire ? S_RESEND : S_STATUS;
            end
            S_RESEND: begin
                if (stat.out_free) begin
                    cmd        = tsr_pkg::CMD_RESEND;
                    state_next = S_STATUS;
                end
            end
            S_STATUS: begin
                if (stat.out_free) begin
                    cmd        = tsr_pkg::CMD_STATUS;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ design/tsr_dp.sv @@
// ----------------------------------------------------------------------------
// tsr_dp
// Sequence counters, segment queue, timer and result register.
// ----------------------------------------------------------------------------
module tsr_dp #(
    parameter int QUEUE_DEPTH = tsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tsr_pkg::cmd_t  cmd,
    input  tsr_pkg::in_t   s_data,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output tsr_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output tsr_pkg::out_t  m_data
);

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
    localparam logic [CntW:0]   DepthW = (CntW + 1)'(QUEUE_DEPTH);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
    localparam logic [4:0]      MaxSegsC = 5'(tsr_pkg::MAX_SEGS);

    // configuration
    logic [31:0] iseq_reg;
    logic [15:0] itimeout_reg;
    logic [10:0] maxpay_reg;

    // connection state
    logic [63:0] next_reg, acked_reg, front_reg;
    logic [IdxW-1:0] head_reg;
    logic [CntW-1:0] count_reg;
    logic [16:0] flight_reg;
    logic [31:0] timer_reg, rto_reg;
    logic        running_reg;
    logic [7:0]  retry_reg;
    logic [15:0] pw_reg;
    logic        syn_done_reg, fin_done_reg, errored_reg;

    // per item working registers
    tsr_pkg::in_t in_reg;
    logic [16:0] rem_reg;
    logic [15:0] buf_reg;
    logic [4:0]  k_reg;
    logic        syn_phase_reg;
    logic [63:0] ack_abs_reg;

    // segment queue: {fin, syn, len}
    logic [12:0] mem [QUEUE_DEPTH];
    logic [12:0] rd_reg;

    logic          m_valid_reg;
    tsr_pkg::out_t out_reg;

    // queue pointers
    logic [CntW:0]   tail_sum;
    logic [IdxW-1:0] tail, head_inc;
    logic            q_full;

    assign tail_sum = (CntW + 1)'(head_reg) + {1'b0, count_reg};
    assign tail     = (tail_sum >= DepthW) ? IdxW'(tail_sum - DepthW) : IdxW'(tail_sum);
    assign head_inc = (head_reg == LastIdx) ? '0 : head_reg + 1'b1;
    assign q_full   = (count_reg == DepthC);

    // push step
    logic [16:0] window, rem_init, seqlen, rem_new;
    logic [10:0] pay_a, pay, send_len;
    logic [15:0] buf_new;
    logic        closed, fin_syn, syn_go, fin_d, brk1, brk2, cont, loop_go;
    logic        send, send_syn, send_fin, more;

    always_comb begin
        window   = (pw_reg == '0) ? 17'd1 : {1'b0, pw_reg};
        rem_init = (window > flight_reg) ? window - flight_reg : '0;
        closed   = in_reg.stream_finished;
        fin_syn  = closed && (buf_reg == '0) && !fin_done_reg && (rem_reg >= 17'd2);
        syn_go   = !syn_done_reg && (rem_reg != '0) && !q_full;
        pay_a    = (rem_reg < {6'd0, maxpay_reg}) ? rem_reg[10:0] : maxpay_reg;
        pay      = (buf_reg < {5'd0, pay_a}) ? buf_reg[10:0] : pay_a;
        buf_new  = buf_reg - {5'd0, pay};
        fin_d    = closed && (buf_new == '0) && !fin_done_reg && (rem_reg > {6'd0, pay});
        brk1     = (pay == '0) && (!(closed && (buf_reg == '0)) || fin_done_reg);
        brk2     = (pay == '0) && !fin_d;
        cont     = (rem_reg != '0) && !q_full && (k_reg < MaxSegsC);
        loop_go  = cont && !brk1 && !brk2;
        if (syn_phase_reg) begin
            send     = syn_go;
            send_syn = 1'b1;
            send_fin = fin_syn;
            send_len = '0;
        end else begin
            send     = loop_go;
            send_syn = 1'b0;
            send_fin = fin_d;
            send_len = pay;
        end
        seqlen  = {6'd0, send_len} + {16'd0, send_syn} + {16'd0, send_fin};
        rem_new = rem_reg - seqlen;
        more    = syn_phase_reg ? (!syn_go || (rem_new != '0)) : (loop_go && (pw_reg != '0));
    end

    // unwrap ack against next sequence number
    logic [31:0] off, cplo, cphi, hi;
    always_comb begin
        off  = in_reg.ack_number - iseq_reg;
        cplo = next_reg[31:0];
        cphi = next_reg[63:32];
        hi   = cphi;
        if ((off > cplo) && ((off - cplo) > 32'h8000_0000) && (cphi != '0)) begin
            hi = cphi - 1'b1;
        end else if ((off < cplo) && ((cplo - off) > 32'h8000_0000)) begin
            hi = cphi + 1'b1;
        end
    end

    // head segment and ack retirement
    logic [11:0] head_sl;
    logic [63:0] front_end;
    logic        ack_ok, retire_ok;
    assign head_sl   = {1'b0, rd_reg[10:0]} + {11'd0, rd_reg[11]} + {11'd0, rd_reg[12]};
    assign front_end = front_reg + {52'd0, head_sl};
    assign ack_ok    = in_reg.ack_present && (ack_abs_reg > acked_reg)
                       && (ack_abs_reg <= next_reg);
    assign retire_ok = (count_reg != '0) && (front_end <= acked_reg);

    // timer
    logic [31:0] tl_new, rto_dbl;
    logic        expire;
    assign tl_new  = (in_reg.elapsed_ms >= timer_reg) ? '0 : timer_reg - in_reg.elapsed_ms;
    assign expire  = running_reg && (tl_new == '0) && (count_reg != '0);
    assign rto_dbl = (rto_reg > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {rto_reg[30:0], 1'b0};

    logic emit;
    assign emit = ((cmd == tsr_pkg::CMD_PUSH_STEP) && send)
                  || (cmd == tsr_pkg::CMD_RESEND) || (cmd == tsr_pkg::CMD_STATUS);

    assign stat.out_free  = !m_valid_reg;
    assign stat.push_more = more;
    assign stat.ack_ok    = ack_ok;
    assign stat.retire_ok = retire_ok;
    assign stat.expire    = expire;

    // queue memory
    always_ff @(posedge aclk) begin
        if ((cmd == tsr_pkg::CMD_PUSH_STEP) && send) begin
            mem[tail] <= {send_fin, send_syn, send_len};
        end
        rd_reg <= mem[head_reg];
    end

    // working and result payload registers
    always_ff @(posedge aclk) begin
        if (cmd == tsr_pkg::CMD_CAPTURE) in_reg <= s_data;
        if (cmd == tsr_pkg::CMD_RECV) ack_abs_reg <= {hi, off};
        if (cmd == tsr_pkg::CMD_PUSH_STEP) begin
            if (send) begin
                out_reg.seg_valid     <= 1'b1;
                out_reg.seg_seqno     <= next_reg[31:0] + iseq_reg;
                out_reg.seg_syn       <= send_syn;
                out_reg.seg_fin       <= send_fin;
                out_reg.seg_rst       <= errored_reg;
                out_reg.payload_len   <= send_len;
                out_reg.is_retransmit <= 1'b0;
                out_reg.in_flight     <= flight_reg + seqlen;
                out_reg.retrans_count <= retry_reg;
                out_reg.last          <= 1'b0;
            end
        end else if (cmd == tsr_pkg::CMD_RESEND) begin
            out_reg.seg_valid     <= 1'b1;
            out_reg.seg_seqno     <= front_reg[31:0] + iseq_reg;
            out_reg.seg_syn       <= rd_reg[11];
            out_reg.seg_fin       <= rd_reg[12];
            out_reg.seg_rst       <= errored_reg;
            out_reg.payload_len   <= rd_reg[10:0];
            out_reg.is_retransmit <= 1'b1;
            out_reg.in_flight     <= flight_reg;
            out_reg.retrans_count <= ((pw_reg != '0) && (retry_reg != 8'hFF))
                                     ? retry_reg + 1'b1 : retry_reg;
            out_reg.last          <= 1'b0;
        end else if (cmd == tsr_pkg::CMD_STATUS) begin
            out_reg.seg_valid     <= 1'b0;
            out_reg.seg_seqno     <= next_reg[31:0] + iseq_reg;
            out_reg.seg_syn       <= 1'b0;
            out_reg.seg_fin       <= 1'b0;
            out_reg.seg_rst       <= errored_reg;
            out_reg.payload_len   <= '0;
            out_reg.is_retransmit <= 1'b0;
            out_reg.in_flight     <= flight_reg;
            out_reg.retrans_count <= retry_reg;
            out_reg.last          <= 1'b1;
        end
    end

    // connection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iseq_reg      <= '0;
            itimeout_reg  <= tsr_pkg::TIMEOUT_RESET;
            maxpay_reg    <= tsr_pkg::PAYLOAD_RESET;
            next_reg      <= '0;
            acked_reg     <= '0;
            front_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            flight_reg    <= '0;
            timer_reg     <= {16'd0, tsr_pkg::TIMEOUT_RESET};
            rto_reg       <= {16'd0, tsr_pkg::TIMEOUT_RESET};
            running_reg   <= 1'b0;
            retry_reg     <= '0;
            pw_reg        <= 16'd1;
            syn_done_reg  <= 1'b0;
            fin_done_reg  <= 1'b0;
            errored_reg   <= 1'b0;
            rem_reg       <= '0;
            buf_reg       <= '0;
            k_reg         <= '0;
            syn_phase_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // result register handshake
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    tsr_pkg::CFG_INITIAL_SEQUENCE: iseq_reg <= cfg_data;
                    tsr_pkg::CFG_INITIAL_TIMEOUT: begin
                        itimeout_reg <= cfg_data[15:0];
                        rto_reg      <= {16'd0, cfg_data[15:0]};
                        if (!running_reg) timer_reg <= {16'd0, cfg_data[15:0]};
                    end
                    tsr_pkg::CFG_MAX_PAYLOAD: maxpay_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            case (cmd)
                tsr_pkg::CMD_PUSH_INIT: begin
                    rem_reg       <= rem_init;
                    buf_reg       <= in_reg.stream_bytes;
                    k_reg         <= '0;
                    syn_phase_reg <= 1'b1;
                end
                tsr_pkg::CMD_PUSH_STEP: begin
                    syn_phase_reg <= 1'b0;
                    if (!syn_phase_reg) buf_reg <= buf_new;
                    if (send) begin
                        rem_reg    <= rem_new;
                        k_reg      <= k_reg + 1'b1;
                        count_reg  <= count_reg + 1'b1;
                        flight_reg <= flight_reg + seqlen;
                        next_reg   <= next_reg + {47'd0, seqlen};
                        if (send_syn) syn_done_reg <= 1'b1;
                        if (send_fin) fin_done_reg <= 1'b1;
                        if (!running_reg) begin
                            timer_reg   <= rto_reg;
                            running_reg <= 1'b1;
                        end
                    end
                end
                tsr_pkg::CMD_RECV: begin
                    if (in_reg.peer_reset) errored_reg <= 1'b1;
                    pw_reg <= in_reg.window_advert;
                end
                tsr_pkg::CMD_ACK_CHECK: begin
                    if (ack_ok) acked_reg <= ack_abs_reg;
                end
                tsr_pkg::CMD_RETIRE: begin
                    if (retire_ok) begin
                        front_reg  <= front_end;
                        flight_reg <= (flight_reg >= {5'd0, head_sl})
                                      ? flight_reg - {5'd0, head_sl} : '0;
                        head_reg   <= head_inc;
                        count_reg  <= count_reg - 1'b1;
                    end else begin
                        retry_reg   <= '0;
                        rto_reg     <= {16'd0, itimeout_reg};
                        timer_reg   <= (count_reg != '0) ? {16'd0, itimeout_reg} : timer_reg;
                        running_reg <= (count_reg != '0);
                    end
                end
                tsr_pkg::CMD_TICK: begin
                    if (running_reg) timer_reg <= tl_new;
                end
                tsr_pkg::CMD_RESEND: begin
                    if (pw_reg != '0) begin
                        if (retry_reg != 8'hFF) retry_reg <= retry_reg + 1'b1;
                        rto_reg   <= rto_dbl;
                        timer_reg <= rto_dbl;
                    end else begin
                        timer_reg <= rto_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DepthC) else $error("queue count above depth");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !m_valid_reg) else $error("result register overwritten");
    a_empty_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (flight_reg == '0)) else $error("flight with empty queue");
    a_retire_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cmd == tsr_pkg::CMD_RETIRE) && retire_ok) |=> (front_reg <= acked_reg))
        else $error("front passed acknowledged sequence");
`endif

endmodule

@@ design/tcp_sender_retransmit_top.sv @@
// ----------------------------------------------------------------------------
// tcp_sender_retransmit_top
// TCP sender that emits segment descriptors and resends on timer expiry.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                    payload
//  s_        in         s_valid, s_ready, s_data                 tsr_pkg::in_t
//  m_        out        m_valid, m_ready, m_data                 tsr_pkg::out_t
//  cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
//  one item at a time, taken in the idle cycle; each result holds the single result
//  register until m_ready takes it; a status result ends every item. push: setup,
//  then a step per segment or step that sends nothing (unsent syn, closing step).
//  receive: receive and ack check, then on a new ack wait and retire per retired
//  entry plus a final head check. tick: a tick step plus the resend on expiry.
//  sync active-low reset spares the queue store and data registers; config anytime.
// ----------------------------------------------------------------------------
module tcp_sender_retransmit_top #(
    parameter int QUEUE_DEPTH = tsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tsr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tsr_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    tsr_pkg::cmd_t  cmd;
    tsr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // state, queue and result register
    tsr_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ sim/tcp_sender_retransmit_top_tb.sv @@
// ----------------------------------------------------------------------------
// tcp_sender_retransmit_top_tb
// Drives pushes, receiver messages and ticks into the tcp sender, predicts
// every segment descriptor and status result, and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_sender_retransmit_top_tb;

    localparam int QDEPTH    = 16;
    localparam int CYCLE_CAP = 2000000;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic [1:0] FL_SYN = 2'b01;
    localparam logic [1:0] FL_FIN = 2'b10;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    tsr_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    tsr_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;

    tcp_sender_retransmit_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted sender state
    logic [31:0] p_iss;
    logic [31:0] p_ito;
    logic [31:0] p_mpay;
    logic [63:0] p_next, p_acked, p_front;
    logic [10:0] p_len [QDEPTH];
    logic [1:0]  p_flg [QDEPTH];
    int unsigned p_head, p_count;
    logic [31:0] p_flight, p_tleft, p_rto;
    logic        p_trun;
    logic [7:0]  p_retry;
    logic [31:0] p_win;
    logic        p_syn_done, p_fin_done, p_err;

    tsr_pkg::in_t  pending_items[$];
    tsr_pkg::out_t expected_segs[$];
    int   errors = 0;
    int   cycles = 0;
    bit   quiet = 0;
    bit   hold_request = 0;
    int   stimulus_done = 0;

    function automatic logic [31:0] wrap_abs(logic [63:0] a);
        return a[31:0] + p_iss;
    endfunction

    function automatic logic [63:0] unwrap_ack(logic [31:0] w, logic [63:0] cp);
        logic [63:0] c;
        c = {cp[63:32], w - p_iss};
        if (c > cp && c - cp > 64'h8000_0000 && c >= 64'h1_0000_0000)
            c = c - 64'h1_0000_0000;
        else if (c < cp && cp - c > 64'h8000_0000)
            c = c + 64'h1_0000_0000;
        return c;
    endfunction

    task automatic emit(logic v, logic [31:0] sq, logic syn, logic fin,
                        logic [10:0] len, logic rx, logic lst);
        tsr_pkg::out_t r;
        r.seg_valid = v; r.seg_seqno = sq; r.seg_syn = syn; r.seg_fin = fin;
        r.seg_rst = p_err; r.payload_len = len; r.is_retransmit = rx;
        r.in_flight = p_flight[16:0]; r.retrans_count = p_retry; r.last = lst;
        expected_segs = {expected_segs, r};
    endtask

    task automatic queue_item(tsr_pkg::in_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic send_segment(logic [31:0] len, logic [1:0] flg, inout int k);
        int unsigned tail;
        logic [31:0] sl;
        tail = (p_head + p_count) % QDEPTH;
        sl = len + flg[0] + flg[1];
        p_len[tail] = len[10:0];
        p_flg[tail] = flg;
        p_count++;
        p_flight = p_flight + sl;
        emit(1'b1, wrap_abs(p_next), flg[0], flg[1], len[10:0], 1'b0, 1'b0);
        k++;
        p_next = p_next + sl;
        if (!p_trun) begin
            p_tleft = p_rto;
            p_trun = 1'b1;
        end
    endtask

    task automatic predict_push(logic [31:0] buffered, logic closed);
        logic [31:0] win, rem, buf_left, pay;
        logic [1:0]  flg;
        int k;
        k = 0;
        win = (p_win != 0) ? p_win : 32'd1;
        rem = (win > p_flight) ? win - p_flight : 32'd0;
        buf_left = buffered;
        if (!p_syn_done && rem > 0 && p_count < QDEPTH) begin
            flg = FL_SYN;
            if (closed && buf_left == 0 && !p_fin_done && rem >= 2) begin
                flg = flg | FL_FIN;
                p_fin_done = 1'b1;
            end
            p_syn_done = 1'b1;
            send_segment(0, flg, k);
            rem = rem - (flg[1] ? 32'd2 : 32'd1);
            if (rem == 0) return;
        end
        while (rem > 0 && p_count < QDEPTH && k < tsr_pkg::MAX_SEGS) begin
            pay = rem;
            flg = 2'b00;
            if (p_mpay < pay) pay = p_mpay;
            if (buf_left < pay) pay = buf_left;
            if (pay == 0 && (!(closed && buf_left == 0) || p_fin_done)) break;
            buf_left = buf_left - pay;
            if (closed && buf_left == 0 && !p_fin_done && rem > pay) begin
                flg = FL_FIN;
                p_fin_done = 1'b1;
            end
            if (pay == 0 && flg == 0) break;
            send_segment(pay, flg, k);
            rem = rem - pay - (flg != 0);
            if (p_win == 0) break;
        end
    endtask

    task automatic predict_receive(tsr_pkg::in_t it);
        logic [63:0] ack;
        logic [31:0] sl;
        if (it.peer_reset) p_err = 1'b1;
        p_win = it.window_advert;
        if (!it.ack_present) return;
        ack = unwrap_ack(it.ack_number, p_next);
        if (!(ack > p_acked && ack <= p_next)) return;
        p_acked = ack;
        while (p_count > 0) begin
            sl = p_len[p_head] + p_flg[p_head][0] + p_flg[p_head][1];
            if (p_front + sl > p_acked) break;
            p_front = p_front + sl;
            p_flight = (p_flight >= sl) ? p_flight - sl : 32'd0;
            p_head = (p_head + 1) % QDEPTH;
            p_count--;
        end
        p_retry = '0;
        p_rto = p_ito;
        if (p_count > 0) begin
            p_tleft = p_rto;
            p_trun = 1'b1;
        end else begin
            p_trun = 1'b0;
        end
    endtask

    task automatic predict_tick(logic [31:0] el);
        if (!p_trun) return;
        p_tleft = (el >= p_tleft) ? 32'd0 : p_tleft - el;
        if (p_tleft != 0 || p_count == 0) return;
        if (p_win > 0) begin
            if (p_retry < 8'd255) p_retry++;
            p_rto = (p_rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : p_rto * 2;
        end
        p_tleft = p_rto;
        emit(1'b1, wrap_abs(p_front), p_flg[p_head][0], p_flg[p_head][1],
             p_len[p_head], 1'b1, 1'b0);
    endtask

    task automatic predict_item(tsr_pkg::in_t it);
        case (it.op)
            tsr_pkg::OP_PUSH: predict_push(it.stream_bytes, it.stream_finished);
            tsr_pkg::OP_RECV: predict_receive(it);
            tsr_pkg::OP_TICK: predict_tick(it.elapsed_ms);
            default: ;
        endcase
        emit(1'b0, wrap_abs(p_next), 1'b0, 1'b0, '0, 1'b0, 1'b1);
    endtask

    task automatic predict_reset();
        p_iss = 0; p_ito = tsr_pkg::TIMEOUT_RESET; p_mpay = tsr_pkg::PAYLOAD_RESET;
        p_next = 0; p_acked = 0; p_front = 0;
        p_head = 0; p_count = 0; p_flight = 0;
        p_tleft = p_ito; p_rto = p_ito; p_trun = 0; p_retry = 0; p_win = 1;
        p_syn_done = 0; p_fin_done = 0; p_err = 0;
    endtask

    // driver: one transfer per accepted item, random idle bursts
    int s_idle = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_item(s_data);
                pending_items.delete(0);
            end
            if (!(s_valid && !s_ready)) begin
                if (s_idle > 0) begin
                    s_idle <= s_idle - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items[0];
                    if (!quiet && $urandom_range(0, 7) == 0)
                        s_idle <= $urandom_range(1, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    int m_idle = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_request && hold_left == 0) begin
                hold_left <= 600;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= (hold_left == 1);
            end else if (m_idle > 0) begin
                m_idle <= m_idle - 1;
                m_ready <= (m_idle == 1);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_idle <= $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        tsr_pkg::out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_segs.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                errors++;
            end else begin
                e = expected_segs[0];
                expected_segs.delete(0);
                if (m_data.seg_valid !== e.seg_valid) begin
                    $error("seg_valid exp %h got %h", e.seg_valid, m_data.seg_valid); errors++;
                end
                if (m_data.seg_seqno !== e.seg_seqno) begin
                    $error("seg_seqno exp %h got %h", e.seg_seqno, m_data.seg_seqno); errors++;
                end
                if (m_data.seg_syn !== e.seg_syn) begin
                    $error("seg_syn exp %h got %h", e.seg_syn, m_data.seg_syn); errors++;
                end
                if (m_data.seg_fin !== e.seg_fin) begin
                    $error("seg_fin exp %h got %h", e.seg_fin, m_data.seg_fin); errors++;
                end
                if (m_data.seg_rst !== e.seg_rst) begin
                    $error("seg_rst exp %h got %h", e.seg_rst, m_data.seg_rst); errors++;
                end
                if (m_data.payload_len !== e.payload_len) begin
                    $error("payload_len exp %0d got %0d", e.payload_len,
                           m_data.payload_len); errors++;
                end
                if (m_data.is_retransmit !== e.is_retransmit) begin
                    $error("is_retransmit exp %h got %h", e.is_retransmit,
                           m_data.is_retransmit); errors++;
                end
                if (m_data.in_flight !== e.in_flight) begin
                    $error("in_flight exp %0d got %0d", e.in_flight, m_data.in_flight);
                    errors++;
                end
                if (m_data.retrans_count !== e.retrans_count) begin
                    $error("retrans_count exp %0d got %0d", e.retrans_count,
                           m_data.retrans_count); errors++;
                end
                if (m_data.last !== e.last) begin
                    $error("last exp %h got %h", e.last, m_data.last); errors++;
                end
            end
        end
    end

    // timeout watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_CAP) begin
            $display("tcp_sender_retransmit_top verification failed");
            $finish;
        end
    end

    function automatic tsr_pkg::in_t mk(logic [1:0] op);
        tsr_pkg::in_t it;
        it = '0;
        it.op = op;
        return it;
    endfunction

    function automatic tsr_pkg::in_t mk_push(logic [15:0] b, logic fin);
        tsr_pkg::in_t it;
        it = mk(tsr_pkg::OP_PUSH);
        it.stream_bytes = b; it.stream_finished = fin;
        return it;
    endfunction

    function automatic tsr_pkg::in_t mk_recv(logic ap, logic [31:0] an, logic [15:0] w,
                                             logic rst);
        tsr_pkg::in_t it;
        it = mk(tsr_pkg::OP_RECV);
        it.ack_present = ap; it.ack_number = an; it.window_advert = w; it.peer_reset = rst;
        return it;
    endfunction

    function automatic tsr_pkg::in_t mk_tick(logic [31:0] el);
        tsr_pkg::in_t it;
        it = mk(tsr_pkg::OP_TICK);
        it.elapsed_ms = el;
        return it;
    endfunction

    // noise in unused fields to toggle every bit
    function automatic tsr_pkg::in_t noisy(tsr_pkg::in_t it);
        tsr_pkg::in_t n;
        n = it;
        if (it.op == tsr_pkg::OP_PUSH) begin
            n.ack_number = $urandom; n.elapsed_ms = $urandom; n.ack_present = $urandom;
            n.window_advert = $urandom; n.peer_reset = 1'b0;
        end else if (it.op == tsr_pkg::OP_TICK) begin
            n.stream_bytes = $urandom; n.stream_finished = $urandom;
            n.ack_number = $urandom;
        end
        return n;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_segs.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            tsr_pkg::CFG_INITIAL_SEQUENCE: p_iss = val;
            tsr_pkg::CFG_INITIAL_TIMEOUT: begin
                p_ito = val[15:0];
                p_rto = p_ito;
                if (!p_trun) p_tleft = p_ito;
            end
            tsr_pkg::CFG_MAX_PAYLOAD: p_mpay = val[10:0];
            default: ;
        endcase
    endtask

    // one connection: syn, data, acks, ticks; mostly well-formed
    task automatic random_phase(int n);
        tsr_pkg::in_t it;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                it = mk_push($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000),
                             $urandom_range(0, 9) == 0);
            end else if (r < 70) begin
                // mostly ack something near the sent range
                it = mk_recv($urandom_range(0, 9) != 0,
                             wrap_abs(p_next) - $urandom_range(0, 2000),
                             $urandom_range(0, 5) == 0 ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 65535),
                             $urandom_range(0, 40) == 0);
                if ($urandom_range(0, 9) == 0) it.ack_number = $urandom;
            end else if (r < 95) begin
                it = mk_tick($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3000));
            end else begin
                it = mk(OP_NOP);
                it.ack_number = $urandom;
            end
            queue_item(noisy(it));
            while (pending_items.size() > 4) @(posedge aclk);
        end
    endtask

    initial begin
        predict_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: handshake, full window, queue full, acks, expiry
        queue_item(mk_push(16'd0, 1'b0));
        queue_item(mk_recv(1'b1, 32'd1, 16'hFFFF, 1'b0));
        queue_item(mk_push(16'hFFFF, 1'b0));
        queue_item(mk_push(16'hFFFF, 1'b0));
        queue_item(mk_tick(32'd999));
        queue_item(mk_tick(32'd1));
        queue_item(mk_tick(32'hFFFF_FFFF));
        queue_item(mk_recv(1'b1, 32'd1001, 16'd0, 1'b0));
        queue_item(mk_recv(1'b1, 32'd5, 16'd0, 1'b0));
        queue_item(mk_push(16'd50, 1'b0));
        queue_item(mk_tick(32'hFFFF_FFFF));
        queue_item(mk_recv(1'b0, 32'hFFFF_FFFF, 16'd3000, 1'b0));
        queue_item(mk(OP_NOP));
        wait_drained();
        // long hold-off while the queue fills
        hold_request = 1;
        wait (hold_left != 0);
        hold_request = 0;
        queue_item(mk_recv(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        queue_item(mk_push(16'hFFFF, 1'b1));
        queue_item(mk_tick(32'd5));
        queue_item(mk_push(16'd0, 1'b1));
        queue_item(mk_recv(1'b1, 32'h0000_0000, 16'd10, 1'b1));
        queue_item(mk_tick(32'hFFFF_FFFF));
        wait_drained();

        // random phases under several settings
        write_reg(tsr_pkg::CFG_INITIAL_SEQUENCE, 32'hFFFF_FFF0);
        write_reg(tsr_pkg::CFG_INITIAL_TIMEOUT, 32'd1);
        write_reg(tsr_pkg::CFG_MAX_PAYLOAD, 32'd1);
        random_phase(50);
        wait_drained();
        write_reg(tsr_pkg::CFG_INITIAL_SEQUENCE, $urandom);
        write_reg(tsr_pkg::CFG_INITIAL_TIMEOUT, 32'd65535);
        write_reg(tsr_pkg::CFG_MAX_PAYLOAD, 32'd1460);
        random_phase(60);
        wait_drained();
        write_reg(tsr_pkg::CFG_INITIAL_SEQUENCE, 32'd0);
        write_reg(tsr_pkg::CFG_INITIAL_TIMEOUT, $urandom_range(1, 65535));
        write_reg(tsr_pkg::CFG_MAX_PAYLOAD, $urandom_range(1, 1460));
        random_phase(60);
        wait_drained();
        write_reg(tsr_pkg::CFG_INITIAL_TIMEOUT, 32'd0);
        write_reg(tsr_pkg::CFG_MAX_PAYLOAD, 32'd0);
        quiet = 1;
        random_phase(40);
        wait_drained();
        repeat (50) @(posedge aclk);

        if (errors == 0 && expected_segs.size() == 0) begin
            $display("tcp_sender_retransmit_top verification clean");
        end else begin
            $display("tcp_sender_retransmit_top verification failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/tsr_pkg.sv
design/tsr_ctrl.sv
design/tsr_dp.sv
design/tcp_sender_retransmit_top.sv
sim/tcp_sender_retransmit_top_tb.sv
